// File: src/clu_pkg.sv
// Shared constants, brand codes, the binary-to-BCD step and the doubled-digit sum of the card number checker.
`default_nettype none
package clu_pkg;

  localparam int CARD_W     = 64;  // card number input width
  localparam int BCD_DIGITS = 20;  // enough decimal digits for any 64-bit value
  localparam int BCD_W      = 4 * BCD_DIGITS;
  localparam int CONV_BITS  = 8;   // binary bits folded into the BCD register per cycle
  localparam int CONV_CYC   = CARD_W / CONV_BITS;
  localparam int CONV_CNT_W = $clog2(CONV_CYC);
  localparam int CNT_W      = 5;   // digit_count width
  localparam int BRAND_W    = 2;
  localparam int OUT_W      = 8;   // brand + luhn_ok + digit_count, one byte
  localparam int MAX_DIGITS = 19;

  typedef logic [3:0] digit_t;

  localparam logic [BRAND_W-1:0] BRAND_NONE   = 2'd0;
  localparam logic [BRAND_W-1:0] BRAND_P4     = 2'd1;
  localparam logic [BRAND_W-1:0] BRAND_P34_37 = 2'd2;
  localparam logic [BRAND_W-1:0] BRAND_P51_55 = 2'd3;

  // Shift CONV_BITS binary bits, MSB first, into a packed BCD value (add-3 then shift).
  function automatic logic [BCD_W-1:0] dabble(input logic [BCD_W-1:0] bcd,
                                              input logic [CONV_BITS-1:0] bits);
    logic [BCD_W-1:0] acc;
    acc = bcd;
    for (int b = CONV_BITS - 1; b >= 0; b--) begin
      for (int k = 0; k < BCD_DIGITS; k++) begin
        if (acc[4*k +: 4] >= 4'd5) begin
          acc[4*k +: 4] = acc[4*k +: 4] + 4'd3;
        end
      end
      acc = {acc[BCD_W-2:0], bits[b]};
    end
    return acc;
  endfunction

  // Digit sum of twice a decimal digit.
  function automatic digit_t dbl_sum(input digit_t d);
    digit_t r;
    if (d < 4'd5) begin
      r = {d[2:0], 1'b0};
    end else begin
      r = {d[2:0], 1'b0} - 4'd9;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// File: src/card_number_luhn_classifier_unit.sv
// Top level: Luhn check, digit count and brand prefix classification of a card number.
//
//  channel  | dir | tdata fields (low bit up)                         | transfer
//  s_axis   | in  | card_number[63:0]                                 | tvalid & tready
//  m_axis   | out | brand[1:0], luhn_ok[2], digit_count[7:3]          | tvalid & tready
//
// An item is first converted and then scanned over N digits (N at most MAX_DIGITS):
// 8 bits at a time are folded into a 20-digit BCD register, then one digit per cycle
// is shifted out of it and accumulated.
// Reset clears the controller and the output valid; no data registers are cleared.
// A stalled output holds its result while the next card number is already accepted
// and converted; the result of that item waits until the output register frees.
`default_nettype none
module card_number_luhn_classifier_unit #(
  parameter int MAX_DIGITS = clu_pkg::MAX_DIGITS
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       s_axis_tvalid,
  output logic                            s_axis_tready,
  input  wire logic [clu_pkg::CARD_W-1:0] s_axis_tdata,  // card_number[63:0]
  output logic                            m_axis_tvalid,
  input  wire logic                       m_axis_tready,
  output logic [clu_pkg::OUT_W-1:0]       m_axis_tdata   // brand[1:0], luhn_ok[2], digit_count[7:3]
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_CONV = 2'd1;
  localparam logic [1:0] S_SCAN = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  localparam logic [clu_pkg::CNT_W-1:0] MAX_CNT = clu_pkg::CNT_W'(MAX_DIGITS);
  localparam logic [clu_pkg::CNT_W-1:0] OVF_CNT = clu_pkg::CNT_W'(MAX_DIGITS + 1);

  logic [1:0]                       state_q, state_d;
  logic [clu_pkg::CONV_CNT_W-1:0]   conv_cnt_q, conv_cnt_d;
  logic [clu_pkg::CARD_W-1:0]       bin_q, bin_d;
  logic [clu_pkg::BCD_W-1:0]        bcd_q, bcd_d;
  logic [clu_pkg::CNT_W-1:0]        cnt_q, cnt_d;
  clu_pkg::digit_t                  sum_q, sum_d;
  clu_pkg::digit_t                  top_q, top_d;
  clu_pkg::digit_t                  below_q, below_d;
  logic [clu_pkg::OUT_W-1:0]        res_q, res_d;
  logic [clu_pkg::OUT_W-1:0]        out_q, out_d;
  logic                             out_vld_q, out_vld_d;

  logic                             in_xfer;
  logic                             out_free;
  logic                             scan_end;
  logic                             bcd_zero;
  clu_pkg::digit_t                  dig;
  clu_pkg::digit_t                  add_v;
  logic [4:0]                       sum_raw;
  logic                             luhn_ok;
  logic [clu_pkg::BRAND_W-1:0]      brand;

  assign s_axis_tready = (state_q == S_IDLE);
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_vld_q || m_axis_tready;
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_q;

  assign bcd_zero = (bcd_q == '0);
  assign scan_end = bcd_zero || (cnt_q == MAX_CNT);
  assign dig      = bcd_q[3:0];
  // odd positions from the right add the digit, even positions its doubled digit sum
  assign add_v    = cnt_q[0] ? clu_pkg::dbl_sum(dig) : dig;
  assign sum_raw  = {1'b0, sum_q} + {1'b0, add_v};
  assign luhn_ok  = (sum_q == 4'd0);

  always_comb begin
    brand = clu_pkg::BRAND_NONE;
    if (top_q == 4'd4 && (cnt_q == 5'd13 || cnt_q == 5'd16)) begin
      brand = clu_pkg::BRAND_P4;
    end else if (cnt_q == 5'd15 && top_q == 4'd3 && (below_q == 4'd4 || below_q == 4'd7)) begin
      brand = clu_pkg::BRAND_P34_37;
    end else if (cnt_q == 5'd16 && top_q == 4'd5 && below_q >= 4'd1 && below_q <= 4'd5) begin
      brand = clu_pkg::BRAND_P51_55;
    end
  end

  always_comb begin
    state_d    = state_q;
    conv_cnt_d = conv_cnt_q;
    bin_d      = bin_q;
    bcd_d      = bcd_q;
    cnt_d      = cnt_q;
    sum_d      = sum_q;
    top_d      = top_q;
    below_d    = below_q;
    res_d      = res_q;
    out_d      = out_q;
    out_vld_d  = out_vld_q;

    if (out_vld_q && m_axis_tready) begin
      out_vld_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          bin_d      = s_axis_tdata;
          bcd_d      = '0;
          conv_cnt_d = '0;
          cnt_d      = '0;
          sum_d      = '0;
          top_d      = '0;
          below_d    = '0;
          state_d    = S_CONV;
        end
      end
      S_CONV: begin
        bcd_d = clu_pkg::dabble(bcd_q,
                                bin_q[clu_pkg::CARD_W-1 -: clu_pkg::CONV_BITS]);
        bin_d = {bin_q[clu_pkg::CARD_W-clu_pkg::CONV_BITS-1:0],
                 {clu_pkg::CONV_BITS{1'b0}}};
        conv_cnt_d = conv_cnt_q + 1'b1;
        if (conv_cnt_q == clu_pkg::CONV_CNT_W'(clu_pkg::CONV_CYC - 1)) begin
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        if (scan_end) begin
          // digits left over after MAX_DIGITS mark an overflow
          if (!bcd_zero) begin
            res_d = {OVF_CNT, 1'b0, clu_pkg::BRAND_NONE};
          end else begin
            res_d = {cnt_q, luhn_ok, luhn_ok ? brand : clu_pkg::BRAND_NONE};
          end
          state_d = S_DONE;
        end else begin
          bcd_d   = {4'd0, bcd_q[clu_pkg::BCD_W-1:4]};
          cnt_d   = cnt_q + 1'b1;
          sum_d   = (sum_raw >= 5'd10) ? 4'(sum_raw - 5'd10) : sum_raw[3:0];
          below_d = top_q;
          top_d   = dig;
        end
      end
      S_DONE: begin
        // hold the result until the output register frees
        if (out_free) begin
          out_d     = res_q;
          out_vld_d = 1'b1;
          state_d   = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    conv_cnt_q <= conv_cnt_d;
    bin_q      <= bin_d;
    bcd_q      <= bcd_d;
    cnt_q      <= cnt_d;
    sum_q      <= sum_d;
    top_q      <= top_d;
    below_q    <= below_d;
    res_q      <= res_d;
    out_q      <= out_d;
  end

endmodule
`default_nettype wire

// File: src/clu_checker.sv
// Port-level checker for the card number classifier, bound to the top level.
`default_nettype none
module clu_checker (
  input wire logic                       clk_i,
  input wire logic                       rst_ni,
  input wire logic                       s_axis_tvalid,
  input wire logic                       s_axis_tready,
  input wire logic                       m_axis_tvalid,
  input wire logic                       m_axis_tready,
  input wire logic [clu_pkg::OUT_W-1:0]  m_axis_tdata
);

  logic [clu_pkg::BRAND_W-1:0] brand;
  logic                        luhn_ok;
  logic [clu_pkg::CNT_W-1:0]   dcnt;

  assign brand   = m_axis_tdata[1:0];
  assign luhn_ok = m_axis_tdata[2];
  assign dcnt    = m_axis_tdata[7:3];

  // a held result stays offered until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output result dropped or changed while stalled");

  // the unit works on one card number at a time
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("second card number taken while busy");

  a_brand_luhn: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && brand != clu_pkg::BRAND_NONE |-> luhn_ok)
    else $error("brand given without a passing Luhn check");

  a_brand_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && brand != clu_pkg::BRAND_NONE |->
      dcnt == 5'd13 || dcnt == 5'd15 || dcnt == 5'd16)
    else $error("brand given for a length no prefix allows");

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> dcnt <= 5'(clu_pkg::MAX_DIGITS + 1))
    else $error("digit count out of range");

endmodule

bind card_number_luhn_classifier_unit clu_checker u_clu_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
`default_nettype wire
